@@ rtl/pmtud_pkg.sv @@
package pmtud_pkg;

	// Event codes carried in s_tuser
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_OUTCOME = 2'd2;
	localparam logic [1:0] OP_ACK     = 2'd3;

	// Send outcome codes
	localparam logic [1:0] OUT_SENT  = 2'd0;
	localparam logic [1:0] OUT_DEFER = 2'd1;
	localparam logic [1:0] OUT_BIG   = 2'd2;
	localparam logic [1:0] OUT_FATAL = 2'd3;

	// Search phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WAIT  = 2'd1;
	localparam logic [1:0] PH_PROBE = 2'd2;
	localparam logic [1:0] PH_SEND  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_PEER_MAX  = 2'd0;
	localparam logic [1:0] CFG_PRECISION = 2'd1;
	localparam logic [1:0] CFG_DELAY     = 2'd2;

	localparam int PROBE_SLOTS = 3;
	localparam int SLOT_W      = $clog2(PROBE_SLOTS);

	localparam logic [15:0] MIN_MTU         = 16'd1200;
	localparam logic [15:0] RESET_PEER_MAX  = 16'd1472;
	localparam logic [10:0] RESET_PRECISION = 11'd16;
	localparam logic [15:0] RESET_DELAY     = 16'd100;
	localparam logic [2:0]  RETRY_SAT       = 3'd7;

	typedef struct packed {
		logic [15:0] peer_max;
		logic [10:0] precision;
		logic [15:0] delay;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_ms;
		logic [19:0] pto_ms;
		logic [15:0] start_mtu;
		logic [15:0] start_upper_bound;
		logic [1:0]  send_outcome;
		logic [61:0] packet_number;
		logic [61:0] ack_low;
		logic [61:0] ack_high;
	} item_t;

	typedef struct packed {
		logic        probe_request;
		logic [15:0] probe_size;
		logic [15:0] current_mtu;
		logic [15:0] upper_bound;
		logic [1:0]  search_phase;
		logic [31:0] deadline_ms;
		logic        fatal_error;
	} res_t;

	typedef struct packed {
		logic        done;
		logic        bounded;
		logic [15:0] trial;
		logic [15:0] bound;
		logic [31:0] expiry;
	} sched_t;

	typedef struct packed {
		logic              clear;
		logic              wr;
		logic [SLOT_W-1:0] idx;
	} rec_ctl_t;

endpackage

@@ rtl/path_mtu_discovery_search_top.sv @@
// Channel  Direction  Accept when                Payload
// s_*      in         s_tvalid & s_tready        tuser: operation; tdata: event fields
// m_*      out        m_tvalid & m_tready        tdata: one result per event
// cfg_*    in         cfg_valid & cfg_ready      cfg_index selects register, cfg_data
//
// One event is accepted per cycle while the output is not stalled; each passes an
// input register and the update logic into the result register, which drives m_*.
// The rate is set by the state update between the two registers.
// Reset clears the search state and the probe record flags and returns the
// configuration to its defaults.
// A stalled output holds its result and the event behind it; the input register
// takes an event while it is empty or its event moves to the output register.
module path_mtu_discovery_search_top import pmtud_pkg::*; #(
	parameter int RETRY_LIMIT = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] now_ms, [51:32] pto_ms, [67:52] start_mtu, [83:68] start_upper_bound,
	// [85:84] send_outcome, [147:86] packet_number, [209:148] ack_low,
	// [271:210] ack_high
	input  logic [271:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] probe_request, [16:1] probe_size, [32:17] current_mtu, [48:33] upper_bound,
	// [50:49] search_phase, [82:51] deadline_ms, [83] fatal_error, [87:84] zero
	output logic [87:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cfg_t  cfg_q;
	logic  valid_s1;
	item_t item_s1;
	logic  valid_s2;
	res_t  res_s2;
	res_t  res;
	logic  advance;
	logic  fire;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peer_max  <= RESET_PEER_MAX;
			cfg_q.precision <= RESET_PRECISION;
			cfg_q.delay     <= RESET_DELAY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PEER_MAX:  cfg_q.peer_max  <= cfg_data;
				CFG_PRECISION: cfg_q.precision <= cfg_data[10:0];
				CFG_DELAY:     cfg_q.delay     <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// Handshake: advance when the result register is empty or being drained
	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation         <= s_tuser;
			item_s1.now_ms            <= s_tdata[31:0];
			item_s1.pto_ms            <= s_tdata[51:32];
			item_s1.start_mtu         <= s_tdata[67:52];
			item_s1.start_upper_bound <= s_tdata[83:68];
			item_s1.send_outcome      <= s_tdata[85:84];
			item_s1.packet_number     <= s_tdata[147:86];
			item_s1.ack_low           <= s_tdata[209:148];
			item_s1.ack_high          <= s_tdata[271:210];
		end
	end

	pmtud_ctrl #(
		.RETRY_LIMIT (RETRY_LIMIT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.fatal_error, res_s2.deadline_ms, res_s2.search_phase,
		res_s2.upper_bound, res_s2.current_mtu, res_s2.probe_size, res_s2.probe_request};

	// A fatal outcome always leaves the search idle
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.fatal_error |-> res_s2.search_phase == PH_IDLE)
		else $error("fatal result with search not idle");

	// A probe request always waits for a send outcome
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.probe_request |-> res_s2.search_phase == PH_SEND)
		else $error("probe request outside awaiting phase");

	// An event that leaves the input register shows up as a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed event produced no result");

	// Fatal and probe request never come together
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.fatal_error && res_s2.probe_request))
		else $error("fatal result also requests a probe");

endmodule

@@ rtl/pmtud_sched.sv @@
module pmtud_sched import pmtud_pkg::*; (
	input  cfg_t        cfg,
	input  logic [15:0] mtu,
	input  logic [15:0] bound,
	input  logic [31:0] now_ms,
	output sched_t      sched
);

	logic [16:0] limit;
	logic [16:0] sum;
	logic [16:0] dbl;

	// Next probe size: bisect with a bound, else double up to the peer ceiling
	always_comb begin
		limit = {1'b0, mtu} + 17'(cfg.precision);
		sum   = {1'b0, mtu} + {1'b0, bound};
		dbl   = {mtu, 1'b0};
		sched.done    = ({1'b0, bound} <= limit);
		sched.bounded = (bound != 16'd0);
		sched.expiry  = now_ms + 32'(cfg.delay);
		if (sched.bounded) begin
			sched.trial = sum[16:1];
			sched.bound = bound;
		end else if (dbl >= {1'b0, cfg.peer_max}) begin
			sched.trial = cfg.peer_max;
			sched.bound = cfg.peer_max;
		end else begin
			sched.trial = dbl[15:0];
			sched.bound = bound;
		end
	end

endmodule

@@ rtl/pmtud_rec.sv @@
module pmtud_rec import pmtud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_ctl_t    ctl,
	input  logic [61:0] packet_number,
	input  logic [61:0] ack_low,
	input  logic [61:0] ack_high,
	output logic        hit
);

	logic [PROBE_SLOTS-1:0] valid_q;
	logic [61:0]            num_q [PROBE_SLOTS];

	// Track which slots hold a recorded probe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[ctl.idx] <= 1'b1;
		end
	end

	// Store packet numbers of sent probes
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			num_q[ctl.idx] <= packet_number;
		end
	end

	// Match any recorded probe against the acknowledged range
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < PROBE_SLOTS; i++) begin
			if (valid_q[i] && num_q[i] >= ack_low && num_q[i] <= ack_high) begin
				hit = 1'b1;
			end
		end
	end

endmodule

@@ rtl/pmtud_ctrl.sv @@
module pmtud_ctrl import pmtud_pkg::*; #(
	parameter int RETRY_LIMIT = 3
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	localparam logic [2:0] LIMIT = 3'(RETRY_LIMIT);

	logic [1:0]  phase_q, phase_n;
	logic [15:0] mtu_q, mtu_n;
	logic [15:0] bound_q, bound_n;
	logic [15:0] trial_q, trial_n;
	logic [2:0]  retry_q, retry_n;
	logic [31:0] expiry_q, expiry_n;
	logic        from_delay_q, from_delay_n;

	logic [15:0] sched_mtu;
	logic [15:0] sched_bound;
	sched_t      sched;
	rec_ctl_t    rec_ctl;
	logic        hit;
	logic [31:0] diff;
	logic        expired;
	logic [2:0]  retry_inc;
	logic [31:0] backoff;
	logic        do_sched;
	logic        req;
	logic        fatal;

	// Pick the MTU and bound that the scheduler works from
	always_comb begin
		case (item.operation)
			OP_START: begin
				sched_mtu   = item.start_mtu;
				sched_bound = item.start_upper_bound;
			end
			OP_ACK: begin
				sched_mtu   = trial_q;
				sched_bound = bound_q;
			end
			default: begin
				sched_mtu   = mtu_q;
				sched_bound = trial_q;
			end
		endcase
	end

	pmtud_sched u_sched (
		.cfg    (cfg),
		.mtu    (sched_mtu),
		.bound  (sched_bound),
		.now_ms (item.now_ms),
		.sched  (sched)
	);

	pmtud_rec u_rec (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (rec_ctl),
		.packet_number (item.packet_number),
		.ack_low       (item.ack_low),
		.ack_high      (item.ack_high),
		.hit           (hit)
	);

	// Next state for the current event
	always_comb begin
		phase_n      = phase_q;
		mtu_n        = mtu_q;
		bound_n      = bound_q;
		trial_n      = trial_q;
		retry_n      = retry_q;
		expiry_n     = expiry_q;
		from_delay_n = from_delay_q;
		rec_ctl      = '0;
		do_sched     = 1'b0;
		req          = 1'b0;
		fatal        = 1'b0;

		diff      = expiry_q - item.now_ms;
		expired   = (diff == 32'd0) || diff[31];
		retry_inc = (retry_q != RETRY_SAT) ? retry_q + 3'd1 : retry_q;
		backoff   = 32'(item.pto_ms) << retry_q;

		case (item.operation)
			OP_START: begin
				mtu_n    = item.start_mtu;
				bound_n  = item.start_upper_bound;
				do_sched = 1'b1;
			end
			OP_TICK: begin
				if (expired && phase_q == PH_WAIT) begin
					retry_n       = 3'd0;
					rec_ctl.clear = 1'b1;
					from_delay_n  = 1'b1;
					phase_n       = PH_SEND;
					req           = 1'b1;
				end else if (expired && phase_q == PH_PROBE) begin
					retry_n = retry_inc;
					if (retry_inc < LIMIT) begin
						from_delay_n = 1'b0;
						phase_n      = PH_SEND;
						req          = 1'b1;
					end else begin
						bound_n  = trial_q;
						do_sched = 1'b1;
					end
				end
			end
			OP_OUTCOME: begin
				if (phase_q == PH_SEND) begin
					if (item.send_outcome inside {OUT_SENT, OUT_DEFER}) begin
						if (item.send_outcome == OUT_SENT && retry_q < 3'(PROBE_SLOTS)) begin
							rec_ctl.wr  = 1'b1;
							rec_ctl.idx = retry_q[SLOT_W-1:0];
						end
						expiry_n = item.now_ms + backoff;
						phase_n  = PH_PROBE;
					end else if (item.send_outcome == OUT_BIG) begin
						bound_n = trial_q;
						if (from_delay_q) begin
							if (sched.done) begin
								phase_n = PH_IDLE;
							end else begin
								trial_n       = sched.trial;
								retry_n       = 3'd0;
								rec_ctl.clear = 1'b1;
								req           = 1'b1;
							end
						end else begin
							do_sched = 1'b1;
						end
					end else begin
						phase_n = PH_IDLE;
						fatal   = 1'b1;
					end
				end
			end
			OP_ACK: begin
				if (phase_q == PH_PROBE && hit) begin
					mtu_n    = trial_q;
					do_sched = 1'b1;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase

		// Reschedule: finish when the bound is close enough, else wait to probe
		if (do_sched) begin
			bound_n = sched.bound;
			if (sched.bounded && sched.done) begin
				phase_n = PH_IDLE;
			end else begin
				trial_n  = sched.trial;
				expiry_n = sched.expiry;
				phase_n  = PH_WAIT;
			end
		end

		// Touch the probe records only when the event moves on
		if (!fire) begin
			rec_ctl = '0;
		end

		res.probe_request = req;
		res.probe_size    = trial_n;
		res.current_mtu   = mtu_n;
		res.upper_bound   = bound_n;
		res.search_phase  = phase_n;
		res.deadline_ms   = expiry_n;
		res.fatal_error   = fatal;
	end

	// Commit state when the event moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			mtu_q        <= MIN_MTU;
			bound_q      <= '0;
			trial_q      <= '0;
			retry_q      <= '0;
			expiry_q     <= '0;
			from_delay_q <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_n;
			mtu_q        <= mtu_n;
			bound_q      <= bound_n;
			trial_q      <= trial_n;
			retry_q      <= retry_n;
			expiry_q     <= expiry_n;
			from_delay_q <= from_delay_n;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pmtud_pkg::*;

	localparam int          SEARCH_RETRIES = 3;
	localparam int          STALL_LIMIT    = 400;
	localparam int          SHOW_LIMIT     = 10;
	localparam int          PHASE_ITEMS    = 90;
	localparam logic [61:0] PN_MAX         = '1;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [271:0] s_tdata   = '0;
	logic [1:0]   s_tuser   = OP_START;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [87:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = CFG_PEER_MAX;
	logic [15:0]  cfg_data  = '0;

	path_mtu_discovery_search_top #(.RETRY_LIMIT(SEARCH_RETRIES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Search state mirrored by the testbench
	logic [1:0]  ph;
	logic [15:0] mtu_q;
	logic [15:0] bound_q;
	logic [15:0] trial_q;
	logic [2:0]  retries;
	logic [31:0] expiry_q;
	logic        after_delay;
	logic [61:0] probe_pn [PROBE_SLOTS];
	logic        probe_seen [PROBE_SLOTS];
	logic [15:0] peer_max_q;
	logic [10:0] precision_q;
	logic [15:0] delay_q;

	item_t event_q[$];
	item_t on_wire;
	res_t  predicted_q[$];

	int queued_count  = 0;
	int accepted_count = 0;
	int results_seen  = 0;
	int fail_count    = 0;
	int shown_count   = 0;
	int send_wait     = 0;
	int recv_wait     = 0;
	int send_burst    = 0;
	int recv_burst    = 0;
	int stall_cycles  = 0;

	function automatic logic bound_reached();
		logic [31:0] lim;
		lim = 32'(mtu_q) + 32'(precision_q);
		return 32'(bound_q) <= lim;
	endfunction

	function automatic void forget_probes();
		for (int i = 0; i < PROBE_SLOTS; i++)
			probe_seen[i] = 1'b0;
	endfunction

	// Pick the next probe size and arm the delay, or stop when the gap is closed
	function automatic void plan_probe(logic [31:0] now);
		logic [31:0] sum;
		logic [31:0] dbl;
		if (bound_q != 0) begin
			if (bound_reached()) begin
				ph = PH_IDLE;
				return;
			end
			sum = 32'(mtu_q) + 32'(bound_q);
			trial_q = sum[16:1];
		end else begin
			dbl = {15'd0, mtu_q, 1'b0};
			if (dbl >= 32'(peer_max_q)) begin
				dbl = 32'(peer_max_q);
				bound_q = peer_max_q;
			end
			trial_q = dbl[15:0];
		end
		ph = PH_WAIT;
		expiry_q = now + 32'(delay_q);
	endfunction

	// Advance the mirrored search by one event and build the result it yields
	function automatic res_t search_step(item_t ev);
		res_t        r;
		logic        req;
		logic        fatal;
		logic        lapsed;
		logic        hit;
		logic [31:0] left;
		req = 1'b0;
		fatal = 1'b0;
		case (ev.operation)
			OP_START: begin
				mtu_q = ev.start_mtu;
				bound_q = ev.start_upper_bound;
				plan_probe(ev.now_ms);
			end
			OP_TICK: begin
				left = expiry_q - ev.now_ms;
				lapsed = (left == 0) || left[31];
				if (lapsed && ph == PH_WAIT) begin
					retries = '0;
					forget_probes();
					after_delay = 1'b1;
					ph = PH_SEND;
					req = 1'b1;
				end else if (lapsed && ph == PH_PROBE) begin
					if (retries != RETRY_SAT)
						retries = retries + 3'd1;
					if (32'(retries) < SEARCH_RETRIES) begin
						after_delay = 1'b0;
						ph = PH_SEND;
						req = 1'b1;
					end else begin
						bound_q = trial_q;
						plan_probe(ev.now_ms);
					end
				end
			end
			OP_OUTCOME: begin
				if (ph == PH_SEND) begin
					case (ev.send_outcome)
						OUT_SENT, OUT_DEFER: begin
							if (ev.send_outcome == OUT_SENT && 32'(retries) < PROBE_SLOTS) begin
								probe_pn[retries[1:0]] = ev.packet_number;
								probe_seen[retries[1:0]] = 1'b1;
							end
							expiry_q = ev.now_ms + ({12'd0, ev.pto_ms} << retries);
							ph = PH_PROBE;
						end
						OUT_BIG: begin
							bound_q = trial_q;
							if (!after_delay) begin
								plan_probe(ev.now_ms);
							end else if (bound_reached()) begin
								ph = PH_IDLE;
							end else begin
								left = 32'(mtu_q) + 32'(bound_q);
								trial_q = left[16:1];
								retries = '0;
								forget_probes();
								req = 1'b1;
							end
						end
						OUT_FATAL: begin
							ph = PH_IDLE;
							fatal = 1'b1;
						end
					endcase
				end
			end
			OP_ACK: begin
				if (ph == PH_PROBE) begin
					hit = 1'b0;
					for (int i = 0; i < PROBE_SLOTS; i++)
						if (probe_seen[i] && probe_pn[i] >= ev.ack_low && probe_pn[i] <= ev.ack_high)
							hit = 1'b1;
					if (hit) begin
						mtu_q = trial_q;
						plan_probe(ev.now_ms);
					end
				end
			end
		endcase
		r.probe_request = req;
		r.probe_size    = trial_q;
		r.current_mtu   = mtu_q;
		r.upper_bound   = bound_q;
		r.search_phase  = ph;
		r.deadline_ms   = expiry_q;
		r.fatal_error   = fatal;
		return r;
	endfunction

	// Idle cycles before the next transaction, with occasional runs of none
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	function automatic logic [61:0] rand_pn();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[61:0];
	endfunction

	function automatic item_t rand_item();
		item_t ev;
		ev.operation         = 2'($urandom_range(0, 3));
		ev.now_ms            = $urandom;
		ev.pto_ms            = 20'($urandom_range(0, 20'hFFFFF));
		ev.start_mtu         = 16'($urandom_range(MIN_MTU, 65527));
		ev.start_upper_bound = 16'($urandom_range(0, 65527));
		ev.send_outcome      = 2'($urandom_range(0, 3));
		ev.packet_number     = rand_pn();
		ev.ack_low           = rand_pn();
		ev.ack_high          = rand_pn();
		return ev;
	endfunction

	// Event builders; unused fields keep random content
	function automatic item_t ev_start(logic [31:0] now, logic [15:0] mtu, logic [15:0] bnd);
		item_t ev;
		ev = rand_item();
		ev.operation = OP_START;
		ev.now_ms = now;
		ev.start_mtu = mtu;
		ev.start_upper_bound = bnd;
		return ev;
	endfunction

	function automatic item_t ev_tick(logic [31:0] now);
		item_t ev;
		ev = rand_item();
		ev.operation = OP_TICK;
		ev.now_ms = now;
		return ev;
	endfunction

	function automatic item_t ev_outcome(logic [31:0] now, logic [19:0] pto, logic [1:0] code,
		logic [61:0] pn);
		item_t ev;
		ev = rand_item();
		ev.operation = OP_OUTCOME;
		ev.now_ms = now;
		ev.pto_ms = pto;
		ev.send_outcome = code;
		ev.packet_number = pn;
		return ev;
	endfunction

	function automatic item_t ev_ack(logic [31:0] now, logic [61:0] lo, logic [61:0] hi);
		item_t ev;
		ev = rand_item();
		ev.operation = OP_ACK;
		ev.now_ms = now;
		ev.ack_low = lo;
		ev.ack_high = hi;
		return ev;
	endfunction

	task automatic post(item_t ev);
		event_q.push_back(ev);
		queued_count++;
	endtask

	// Post an event, sometimes preceded by a fully random one
	task automatic post_mixed(item_t ev);
		if ($urandom_range(0, 19) == 0)
			post(rand_item());
		post(ev);
	endtask

	// One search from start through several probe rounds
	task automatic add_session();
		logic [31:0] t;
		logic [15:0] mtu;
		logic [15:0] ceil;
		logic [15:0] bnd;
		logic [19:0] pto;
		logic [61:0] pn;
		logic [61:0] reach;
		logic [61:0] lo;
		logic [61:0] hi;
		logic [61:0] sent[$];
		int          roll;
		int          tries;
		t = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;
		ceil = (peer_max_q > MIN_MTU) ? peer_max_q : MIN_MTU;
		if ($urandom_range(0, 7) == 0)
			mtu = 16'($urandom_range(MIN_MTU, 65527));
		else
			mtu = 16'($urandom_range(MIN_MTU, ceil));
		roll = $urandom_range(0, 9);
		if (roll < 5)
			bnd = '0;
		else if (roll < 9)
			bnd = 16'($urandom_range(mtu, 65527));
		else
			bnd = 16'($urandom_range(0, mtu));
		post_mixed(ev_start(t, mtu, bnd));
		repeat ($urandom_range(2, 10)) begin
			// run out the delay, now and then with a tick just short of it first
			if (delay_q != 0 && $urandom_range(0, 4) == 0)
				post_mixed(ev_tick(t + 32'(delay_q) - 32'd1));
			t = t + 32'(delay_q) + $urandom_range(0, 2);
			post_mixed(ev_tick(t));
			sent.delete();
			tries = 0;
			while (tries < 4) begin
				tries++;
				t = t + $urandom_range(0, 3);
				pto = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
				pn = rand_pn();
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					post_mixed(ev_outcome(t, pto, OUT_FATAL, pn));
					break;
				end
				if (roll < 15) begin
					post_mixed(ev_outcome(t, pto, OUT_BIG, pn));
					if ($urandom_range(0, 1) == 0)
						break;
					continue;
				end
				post_mixed(ev_outcome(t, pto, (roll < 27) ? OUT_DEFER : OUT_SENT, pn));
				if (roll >= 27)
					sent.push_back(pn);
				roll = $urandom_range(0, 9);
				// acknowledge a range around one of the recorded probes
				if (roll < 6 && sent.size() != 0) begin
					pn = sent[$urandom_range(0, sent.size() - 1)];
					reach = ($urandom_range(0, 3) == 0) ? rand_pn() : 62'($urandom_range(0, 3));
					lo = (pn > reach) ? pn - reach : '0;
					hi = (PN_MAX - pn > reach) ? pn + reach : PN_MAX;
					t = t + $urandom_range(1, 50);
					post_mixed(ev_ack(t, lo, hi));
					break;
				end
				if (roll < 7)
					post_mixed(ev_ack(t + 32'd1, rand_pn(), rand_pn()));
				// let the probe time out
				t = t + ({12'd0, pto} << 3) + $urandom_range(0, 2);
				post_mixed(ev_tick(t));
			end
		end
	endtask

	task automatic fill_random(int n);
		int goal;
		@(negedge clk);
		goal = queued_count + n;
		while (queued_count < goal)
			add_session();
	endtask

	// Hold off until every event is accepted and every result has come back
	task automatic settle();
		do
			@(posedge clk);
		while (accepted_count != queued_count || predicted_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Called right after a rising edge; mirrors the register on its handshake
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_PEER_MAX:  peer_max_q = data;
			CFG_PRECISION: precision_q = data[10:0];
			CFG_DELAY:     delay_q = data;
			default:       ;
		endcase
	endtask

	task automatic program_search(logic [15:0] peer, logic [10:0] prec, logic [15:0] dly);
		write_reg(CFG_PEER_MAX, peer);
		write_reg(CFG_PRECISION, {5'd0, prec});
		write_reg(CFG_DELAY, dly);
		cfg_valid <= 1'b0;
	endtask

	task automatic show_result(string tag, res_t r);
		$display("  %s req=%0d size=%0d mtu=%0d bound=%0d phase=%0d deadline=%08h fatal=%0d",
			tag, r.probe_request, r.probe_size, r.current_mtu, r.upper_bound,
			r.search_phase, r.deadline_ms, r.fatal_error);
	endtask

	// Drive events; predict each one on its transaction, then wait or load the next
	always @(posedge clk) begin : drive_events
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			gap = send_wait;
			if (s_tvalid && s_tready) begin
				predicted_q.push_back(search_step(on_wire));
				accepted_count++;
				gap = draw_wait(send_burst);
			end
			if (!s_tvalid || s_tready) begin
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					send_wait <= gap - 1;
				end else if (event_q.size() != 0) begin
					on_wire = event_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_wire.operation;
					s_tdata <= {on_wire.ack_high, on_wire.ack_low, on_wire.packet_number,
						on_wire.send_outcome, on_wire.start_upper_bound, on_wire.start_mtu,
						on_wire.pto_ms, on_wire.now_ms};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Take results, compare with the oldest prediction, stall at random
	always @(posedge clk) begin : check_results
		int   gap;
		res_t want;
		res_t got;
		logic bad;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			gap = recv_wait;
			if (m_tvalid && m_tready) begin
				got.probe_request = m_tdata[0];
				got.probe_size    = m_tdata[16:1];
				got.current_mtu   = m_tdata[32:17];
				got.upper_bound   = m_tdata[48:33];
				got.search_phase  = m_tdata[50:49];
				got.deadline_ms   = m_tdata[82:51];
				got.fatal_error   = m_tdata[83];
				if (predicted_q.size() == 0) begin
					fail_count++;
					if (shown_count < SHOW_LIMIT) begin
						shown_count++;
						$display("result %0d arrived with nothing pending", results_seen);
						show_result("got", got);
					end
				end else begin
					want = predicted_q.pop_front();
					bad = (got.probe_request !== want.probe_request) ||
						(got.probe_size !== want.probe_size) ||
						(got.current_mtu !== want.current_mtu) ||
						(got.upper_bound !== want.upper_bound) ||
						(got.search_phase !== want.search_phase) ||
						(got.deadline_ms !== want.deadline_ms) ||
						(got.fatal_error !== want.fatal_error) ||
						(m_tdata[87:84] !== 4'd0);
					if (bad) begin
						fail_count++;
						if (shown_count < SHOW_LIMIT) begin
							shown_count++;
							$display("mismatch on result %0d (pad %h)", results_seen, m_tdata[87:84]);
							show_result("exp", want);
							show_result("got", got);
						end
					end
				end
				results_seen++;
				gap = draw_wait(recv_burst);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				recv_wait <= gap - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// End the run when no transaction of any kind moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		ph = PH_IDLE;
		mtu_q = MIN_MTU;
		bound_q = '0;
		trial_q = '0;
		retries = '0;
		expiry_q = '0;
		after_delay = 1'b0;
		forget_probes();
		peer_max_q = RESET_PEER_MAX;
		precision_q = RESET_PRECISION;
		delay_q = RESET_DELAY;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk at reset settings: peer max 1472, precision 16, delay 100
		post(ev_tick(32'd0));
		post(ev_outcome(32'd0, 20'hFFFFF, OUT_SENT, PN_MAX));
		post(ev_ack(32'd0, '0, PN_MAX));
		post(ev_start(32'd1000, MIN_MTU, 16'd0));
		post(ev_tick(32'd1099));
		post(ev_ack(32'd1099, '0, PN_MAX));
		post(ev_tick(32'd1100));
		post(ev_ack(32'd1100, '0, PN_MAX));
		post(ev_tick(32'd5000));
		post(ev_outcome(32'd1100, 20'hFFFFF, OUT_SENT, PN_MAX));
		post(ev_ack(32'd1200, PN_MAX, '0));
		post(ev_ack(32'd1200, '0, PN_MAX - 1));
		post(ev_tick(32'd1049675));
		post(ev_outcome(32'd1049700, 20'd10, OUT_DEFER, '0));
		post(ev_tick(32'd1049720));
		post(ev_outcome(32'd1049800, 20'd7, OUT_SENT, 62'd5));
		post(ev_tick(32'd1049828));
		post(ev_tick(32'd1049928));
		post(ev_outcome(32'd1049930, 20'd1, OUT_BIG, '0));
		post(ev_outcome(32'd1049931, 20'd4, OUT_SENT, '0));
		post(ev_ack(32'd1049940, '0, '0));
		post(ev_tick(32'hFFFF_FFFF));
		post(ev_start(32'hFFFF_FFC0, 16'd65527, 16'd65527));
		post(ev_start(32'hFFFF_FFC0, MIN_MTU, 16'd65527));
		post(ev_tick(32'h0000_0010));
		post(ev_tick(32'h0000_0024));
		post(ev_outcome(32'h0000_0030, 20'd3, OUT_FATAL, '0));
		settle();

		// Random sessions; each phase drains fully before the settings change
		fill_random(PHASE_ITEMS);
		settle();
		program_search(MIN_MTU, 11'd1, 16'd0);
		fill_random(PHASE_ITEMS);
		settle();
		program_search(16'd65527, 11'd1024, 16'd65535);
		fill_random(PHASE_ITEMS);
		settle();
		program_search(16'd1500, 11'd16, 16'd100);
		fill_random(PHASE_ITEMS);
		settle();
		repeat (3) begin
			program_search(16'($urandom_range(MIN_MTU, 65527)), 11'($urandom_range(1, 1024)),
				16'($urandom_range(0, 65535)));
			fill_random(PHASE_ITEMS);
			settle();
		end

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ path_mtu_discovery_search_top.f @@
rtl/pmtud_pkg.sv
rtl/pmtud_sched.sv
rtl/pmtud_rec.sv
rtl/pmtud_ctrl.sv
rtl/path_mtu_discovery_search_top.sv
tb/sv/tb.sv
